/* hw/rtl/hgvn_pkg.sv */
// ----------------------------------------------------------------------------
// hgvn_pkg
// Shared types, constants and helpers for the heightmap vertex normal block.
// ----------------------------------------------------------------------------
package hgvn_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int SLOT_W    = COL_W + 1;
  localparam int SLOTS     = 2 * MAX_WIDTH;

  // Configuration register indexes
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;

  // Vector with signed Q3.15 (or small integer) components
  typedef struct packed {
    logic signed [18:0] z;
    logic signed [18:0] y;
    logic signed [18:0] x;
  } vec_t;

  // Unit normal, signed Q1.15
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } nrm_t;

  // Grid setup handed from the register block to the core
  typedef struct packed {
    logic        restart;
    logic [10:0] width;
    logic [15:0] height;
  } grid_cfg_t;

  typedef enum logic [2:0] {
    U_IDLE, U_SQ, U_DIV0, U_DIV, U_SQRT, U_FIN
  } unit_state_t;

  typedef enum logic [3:0] {
    C_CLEAR, C_IDLE, C_RD_A, C_RD_C, C_F1_GO, C_F1_WAIT, C_F2_GO, C_F2_WAIT,
    C_ACC_RD, C_ACC_WR, C_EM_RD, C_EM_GO, C_EM_WAIT, C_OUT
  } core_state_t;

  // Line buffer slot of a vertex: row parity selects the line
  function automatic logic [SLOT_W-1:0] slot(input logic row_lsb,
                                             input logic [COL_W-1:0] col);
    return {row_lsb, col};
  endfunction

endpackage

/* hw/rtl/heightmap_grid_vertex_normals.sv */
// ----------------------------------------------------------------------------
// heightmap_grid_vertex_normals
// Vertex normals of a heightmap grid from a raster stream of height bytes.
// ----------------------------------------------------------------------------
// Sequence: a sample finishing a cell gets its two face normals, then each
//   emitted vertex (up to four) is normalized and sent, waiting on m_tready.
// One sample at a time; edge samples that close no cell go straight back to idle.
//   The pace is set by the shared iterative normalizer (divide and root).
// Reset: starts a clearing pass over every entry of the normal sum memory, no
//   input taken; every grid register write starts the same pass.
module heightmap_grid_vertex_normals
  import hgvn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // height_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // vertex_row, vertex_col, vertex_height, normal_x/y/z
  output logic        m_tlast,   // run_end
  output logic        m_tuser    // grid_done
);

  logic [10:0] width_reg;
  logic [15:0] height_reg;
  logic        wr_width, wr_height;
  grid_cfg_t   cfg;

  assign cfg_ready = 1'b1;
  assign wr_width  = cfg_valid && (cfg_index == REG_GRID_WIDTH);
  assign wr_height = cfg_valid && (cfg_index == REG_GRID_HEIGHT);

  // Hold the grid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 11'd256;
      height_reg <= 16'd256;
    end else begin
      if (wr_width)  width_reg  <= cfg_data[10:0];
      if (wr_height) height_reg <= cfg_data;
    end
  end

  // Clamp to the supported grid size
  always_comb begin
    cfg.restart = wr_width || wr_height;
    if (width_reg < 11'd2)             cfg.width = 11'd2;
    else if (width_reg > 11'(MAX_WIDTH)) cfg.width = 11'(MAX_WIDTH);
    else                               cfg.width = width_reg;
    cfg.height = (height_reg < 16'd2) ? 16'd2 : height_reg;
  end

  hgvn_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

/* hw/rtl/hgvn_unit_norm.sv */
// ----------------------------------------------------------------------------
// hgvn_unit_norm
// Iterative vector normalizer: squared length, then per component a
// restoring divide (33 steps) and a digit-by-digit square root (17 steps).
// ----------------------------------------------------------------------------
module hgvn_unit_norm
  import hgvn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  vec_t vec,
  output logic busy,
  output logic done,
  output nrm_t nrm
);

  unit_state_t state, state_next;
  vec_t        v;
  logic [1:0]  k;
  logic [5:0]  cnt;
  logic [37:0] sq [3];
  logic [39:0] len2;
  logic [40:0] rem;
  logic [32:0] q;
  logic [32:0] op;
  logic [33:0] res;
  logic [32:0] one;

  logic signed [18:0] comp;
  logic [18:0] mag;
  logic [37:0] prod;
  logic [40:0] sh;
  logic [33:0] t;
  logic        ge;
  logic [17:0] rp1;
  logic [15:0] n16;
  logic [15:0] res16;

  // Select current component and its magnitude
  always_comb begin
    unique case (k)
      2'd0:    comp = v.x;
      2'd1:    comp = v.y;
      default: comp = v.z;
    endcase
    mag  = comp[18] ? 19'(-comp) : 19'(comp);
    prod = 38'(mag) * 38'(mag);
    sh   = {rem[39:0], 1'b0};
    t    = res + 34'(one);
    ge   = {1'b0, op} >= t;
    rp1  = 18'(res[16:0]) + 18'd1;
    n16  = rp1[16:1];
    res16 = comp[18] ? 16'(~n16 + 16'd1) : (n16[15] ? 16'h7FFF : n16);
  end

  // Raise done once the last component has landed in nrm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == U_FIN) && (k == 2'd2);
    end
  end

  always_comb begin
    state_next = state;
    busy = (state != U_IDLE);
    unique case (state)
      U_IDLE: if (start) state_next = U_SQ;
      U_SQ:   if (k == 2'd2) state_next = U_DIV0;
      U_DIV0: state_next = U_DIV;
      U_DIV:  if (cnt == 6'd31) state_next = U_SQRT;
      U_SQRT: if (cnt == 6'd16) state_next = U_FIN;
      U_FIN: begin
        if (k == 2'd2) begin
          state_next = U_IDLE;
        end else begin
          state_next = U_DIV0;
        end
      end
      default: state_next = U_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      U_IDLE: begin
        v    <= vec;
        k    <= 2'd0;
        len2 <= '0;
      end
      U_SQ: begin
        sq[k] <= prod;
        len2  <= len2 + 40'(prod);
        k     <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      U_DIV0: begin
        cnt <= '0;
        if (41'(sq[k]) >= 41'(len2)) begin
          rem <= 41'(sq[k]) - 41'(len2);
          q   <= 33'd1;
        end else begin
          rem <= 41'(sq[k]);
          q   <= 33'd0;
        end
      end
      U_DIV: begin
        if (sh >= 41'(len2)) begin
          rem <= sh - 41'(len2);
          q   <= {q[31:0], 1'b1};
        end else begin
          rem <= sh;
          q   <= {q[31:0], 1'b0};
        end
        if (cnt == 6'd31) begin
          cnt <= '0;
          op  <= {q[31:0], (sh >= 41'(len2))};
          res <= '0;
          one <= 33'h1_0000_0000;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
      U_SQRT: begin
        if (ge) begin
          op  <= op - t[32:0];
          res <= (res >> 1) + 34'(one);
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
        cnt <= cnt + 6'd1;
      end
      U_FIN: begin
        unique case (k)
          2'd0:    nrm.x <= res16;
          2'd1:    nrm.y <= res16;
          default: nrm.z <= res16;
        endcase
        k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/hgvn_core.sv */
// ----------------------------------------------------------------------------
// hgvn_core
// Line buffer and normal sum memories with the per-sample sequencer:
// face normals, read-modify-write of vertex sums, vertex emission.
// ----------------------------------------------------------------------------
module hgvn_core
  import hgvn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  grid_cfg_t   cfg,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tuser
);

  core_state_t state, state_next;

  logic [SLOT_W-1:0] clr;
  logic [15:0]       row_count;
  logic [COL_W-1:0]  col_count;
  logic [15:0]       cr;
  logic [COL_W-1:0]  cc;
  logic              lc, lr;
  logic [7:0]        ha, hb, hc;
  nrm_t              f1, f2;
  logic [1:0]        idx;
  logic [7:0]        vh;

  logic [15:0] o_row;
  logic [9:0]  o_col;
  logic [7:0]  o_h;
  nrm_t        o_n;

  logic [7:0] hmem [SLOTS];
  vec_t       smem [SLOTS];
  logic [7:0] h_rdata;
  vec_t       s_rdata;

  logic              h_we, s_we;
  logic [SLOT_W-1:0] h_waddr, h_raddr, s_waddr, s_raddr;
  logic [7:0]        h_wdata;
  vec_t              s_wdata;

  logic   un_start, un_busy, un_done;
  vec_t   un_vec;
  nrm_t   un_nrm;

  logic   accept;
  logic   has_next;
  logic [1:0] nxt;
  logic [SLOT_W-1:0] v_slot;
  vec_t   delta;
  logic   is_last_col, is_last_row;
  logic [10:0] col_inc;

  hgvn_unit_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (un_start),
    .vec   (un_vec),
    .busy  (un_busy),
    .done  (un_done),
    .nrm   (un_nrm)
  );

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (h_we) hmem[h_waddr] <= h_wdata;
    h_rdata <= hmem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    s_rdata <= smem[s_raddr];
  end

  assign accept      = s_tvalid && s_tready;
  assign is_last_col = (11'(col_count) == cfg.width - 11'd1);
  assign is_last_row = (row_count == cfg.height - 16'd1);
  assign col_inc     = 11'(col_count) + 11'd1;

  // Vertex slot and summed face normals for vertex code idx
  // (0: upper-left, 1: upper-right, 2: lower-left, 3: lower-right)
  always_comb begin
    v_slot = slot(idx[1] ? cr[0] : ~cr[0], idx[0] ? cc : cc - COL_W'(1));
    unique case (idx)
      2'd0: begin
        delta.x = 19'(f2.x); delta.y = 19'(f2.y); delta.z = 19'(f2.z);
      end
      2'd3: begin
        delta.x = 19'(f1.x); delta.y = 19'(f1.y); delta.z = 19'(f1.z);
      end
      default: begin
        delta.x = 19'(f1.x) + 19'(f2.x);
        delta.y = 19'(f1.y) + 19'(f2.y);
        delta.z = 19'(f1.z) + 19'(f2.z);
      end
    endcase
  end

  // Next vertex to emit after idx
  always_comb begin
    has_next = 1'b0;
    nxt      = idx;
    unique case (idx)
      2'd0: begin
        if (lc) begin
          has_next = 1'b1; nxt = 2'd1;
        end else if (lr) begin
          has_next = 1'b1; nxt = 2'd2;
        end
      end
      2'd1: begin
        if (lr) begin
          has_next = 1'b1; nxt = 2'd2;
        end
      end
      2'd2: begin
        if (lc) begin
          has_next = 1'b1; nxt = 2'd3;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory ports, unit requests
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    h_we       = 1'b0;
    h_waddr    = slot(row_count[0], col_count);
    h_wdata    = s_tdata;
    h_raddr    = v_slot;
    s_we       = 1'b0;
    s_waddr    = v_slot;
    s_wdata    = '0;
    s_raddr    = v_slot;
    un_start   = 1'b0;
    un_vec.x   = 19'(ha) - 19'(hb);
    un_vec.y   = 19'sd10;
    un_vec.z   = 19'(hc) - 19'(hb);
    unique case (state)
      C_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr;
        if (&clr) state_next = C_IDLE;
      end
      C_IDLE: begin
        s_tready = 1'b1;
        h_we     = accept;
        if (accept && row_count != 16'd0 && col_count != '0) state_next = C_RD_A;
      end
      C_RD_A: begin
        h_raddr    = slot(cr[0], cc - COL_W'(1));
        state_next = C_RD_C;
      end
      C_RD_C: begin
        h_raddr    = slot(~cr[0], cc);
        state_next = C_F1_GO;
      end
      C_F1_GO: begin
        h_raddr    = slot(~cr[0], cc - COL_W'(1));
        un_vec.x   = 19'(ha) - 19'(hb);
        un_vec.z   = 19'(h_rdata) - 19'(hb);
        un_start   = 1'b1;
        state_next = C_F1_WAIT;
      end
      C_F1_WAIT: begin
        // keep reading hd so it is ready for the face two start
        h_raddr = slot(~cr[0], cc - COL_W'(1));
        if (un_done) state_next = C_F2_GO;
      end
      C_F2_GO: begin
        // hd has been waiting in the read register since the face one start
        un_vec.x   = 19'(h_rdata) - 19'(hc);
        un_vec.z   = 19'(h_rdata) - 19'(ha);
        un_start   = 1'b1;
        state_next = C_F2_WAIT;
      end
      C_F2_WAIT: if (un_done) state_next = C_ACC_RD;
      C_ACC_RD: state_next = C_ACC_WR;
      C_ACC_WR: begin
        s_we      = 1'b1;
        s_wdata.x = s_rdata.x + delta.x;
        s_wdata.y = s_rdata.y + delta.y;
        s_wdata.z = s_rdata.z + delta.z;
        state_next = (idx == 2'd3) ? C_EM_RD : C_ACC_RD;
      end
      C_EM_RD: state_next = C_EM_GO;
      C_EM_GO: begin
        un_vec     = s_rdata;
        un_start   = 1'b1;
        s_we       = 1'b1;
        state_next = C_EM_WAIT;
      end
      C_EM_WAIT: if (un_done) state_next = C_OUT;
      C_OUT: begin
        if (m_tready) state_next = has_next ? C_EM_RD : C_IDLE;
      end
      default: state_next = C_CLEAR;
    endcase
    if (cfg.restart) state_next = C_CLEAR;
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      clr       <= '0;
      row_count <= '0;
      col_count <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      unique case (state)
        C_CLEAR: clr <= clr + SLOT_W'(1);
        C_IDLE: begin
          if (accept) begin
            cr <= row_count;
            cc <= col_count;
            hb <= s_tdata;
            lc <= is_last_col;
            lr <= is_last_row;
            // advance raster position
            if (col_inc >= cfg.width) begin
              col_count <= '0;
              row_count <= is_last_row ? 16'd0 : row_count + 16'd1;
            end else begin
              col_count <= col_inc[COL_W-1:0];
            end
          end
        end
        C_RD_C:    ha <= h_rdata;
        C_F1_GO:   hc <= h_rdata;
        C_F1_WAIT: if (un_done) f1 <= un_nrm;
        C_F2_WAIT: begin
          if (un_done) begin
            f2  <= un_nrm;
            idx <= 2'd0;
          end
        end
        C_ACC_WR:  idx <= idx + 2'd1;
        C_EM_GO:   vh <= h_rdata;
        C_EM_WAIT: begin
          if (un_done) begin
            m_tvalid <= 1'b1;
            o_row    <= idx[1] ? cr : cr - 16'd1;
            o_col    <= idx[0] ? cc : cc - COL_W'(1);
            o_h      <= vh;
            o_n      <= un_nrm;
            m_tlast  <= !has_next;
            m_tuser  <= !has_next && lc && lr;
          end
        end
        C_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            idx      <= nxt;
          end
        end
        default: ;
      endcase
    end
  end

  // tdata: row, col, height, normal x, y, z from bit 0 up
  assign m_tdata = {6'd0, o_n.z, o_n.y, o_n.x, o_h, o_col, o_row};

`ifndef NO_ASSERTIONS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    11'(col_count) < cfg.width)
    else $error("column counter beyond grid width");
  a_ny_positive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_n.y != 16'sd0 && !o_n.y[15]))
    else $error("emitted normal y not positive");
  a_out_after_unit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(un_done))
    else $error("result raised without a finished normalization");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    un_start |-> !un_busy)
    else $error("normalizer started while busy");
`endif

endmodule

/* tb/sv/heightmap_grid_vertex_normals_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heightmap_grid_vertex_normals_checker
// Watches the config, sample and vertex channels, predicts every vertex
// normal from the accepted height samples and compares each output transfer.
// ----------------------------------------------------------------------------
module heightmap_grid_vertex_normals_checker
  import hgvn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,
  input  logic        m_tlast,
  input  logic        m_tuser,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [15:0]        row;
    logic [9:0]         col;
    logic [7:0]         height;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               run_end;
    logic               grid_done;
  } vertex_t;

  vertex_t     vertex_q[$];
  logic [10:0] width_reg;
  logic [15:0] height_reg;
  logic [7:0]  height_mem[SLOTS];
  int          sum_x[SLOTS];
  int          sum_y[SLOTS];
  int          sum_z[SLOTS];
  int          row_pos;
  int          col_pos;

  function automatic int slot_of(int r, int c);
    return (r % 2) * MAX_WIDTH + (c % MAX_WIDTH);
  endfunction

  function automatic longint unsigned int_root(longint unsigned q);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= q) r = t;
    end
    return r;
  endfunction

  // One Q1.15 component, rounded half up from the truncated root of the ratio
  function automatic int unit_part(longint c, longint unsigned len2);
    logic [127:0]    num;
    longint unsigned mag;
    longint unsigned n;
    if (len2 == 0) return 0;
    mag = (c < 0) ? -c : c;
    num = ({64'd0, mag} * mag) << 32;
    n = (int_root(64'(num / len2)) + 1) >> 1;
    if (c < 0) return -int'(n);
    return (n > 32767) ? 32767 : int'(n);
  endfunction

  task automatic unit_vec(input longint x, input longint y, input longint z,
                          output int ox, output int oy, output int oz);
    longint unsigned len2;
    len2 = x * x + y * y + z * z;
    ox = unit_part(x, len2);
    oy = unit_part(y, len2);
    oz = unit_part(z, len2);
  endtask

  task automatic add_face(input int r, input int c, input int fx, input int fy,
                          input int fz);
    int s;
    s = slot_of(r, c);
    sum_x[s] += fx;
    sum_y[s] += fy;
    sum_z[s] += fz;
  endtask

  task automatic push_vertex(input int r, input int c);
    vertex_t v;
    int      s;
    int      nx, ny, nz;
    s = slot_of(r, c);
    unit_vec(sum_x[s], sum_y[s], sum_z[s], nx, ny, nz);
    v.row = r[15:0];
    v.col = c[9:0];
    v.height = height_mem[s];
    v.nx = nx[15:0];
    v.ny = ny[15:0];
    v.nz = nz[15:0];
    v.run_end = 0;
    v.grid_done = 0;
    vertex_q.push_back(v);
    sum_x[s] = 0;
    sum_y[s] = 0;
    sum_z[s] = 0;
  endtask

  task automatic clear_grid();
    row_pos = 0;
    col_pos = 0;
    for (int i = 0; i < SLOTS; i++) begin
      sum_x[i] = 0;
      sum_y[i] = 0;
      sum_z[i] = 0;
    end
  endtask

  // Accumulate the two faces of the closed cell and release finished vertices
  task automatic take_sample(input logic [7:0] hs);
    int     w, h, r, c;
    int     fx, fy, fz;
    longint ha, hb, hc, hd;
    w = width_reg;
    h = height_reg;
    r = row_pos;
    c = col_pos;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 2) h = 2;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    height_mem[slot_of(r, c)] = hs;
    if (r >= 1 && c >= 1) begin
      ha = height_mem[slot_of(r, c - 1)];
      hb = height_mem[slot_of(r, c)];
      hc = height_mem[slot_of(r - 1, c)];
      hd = height_mem[slot_of(r - 1, c - 1)];
      unit_vec(ha - hb, 10, hc - hb, fx, fy, fz);
      add_face(r, c - 1, fx, fy, fz);
      add_face(r, c, fx, fy, fz);
      add_face(r - 1, c, fx, fy, fz);
      unit_vec(hd - hc, 10, hd - ha, fx, fy, fz);
      add_face(r, c - 1, fx, fy, fz);
      add_face(r - 1, c, fx, fy, fz);
      add_face(r - 1, c - 1, fx, fy, fz);
      push_vertex(r - 1, c - 1);
      if (c == w - 1) push_vertex(r - 1, c);
      if (r == h - 1) begin
        push_vertex(r, c - 1);
        if (c == w - 1) push_vertex(r, c);
      end
      vertex_q[vertex_q.size() - 1].run_end = 1;
      if (r == h - 1 && c == w - 1) vertex_q[vertex_q.size() - 1].grid_done = 1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: vertex mismatch on %s: got %0d, expected %0d", $realtime, what,
             got, want);
    errors++;
  endtask

  task automatic check_vertex();
    vertex_t v;
    if (vertex_q.size() == 0) begin
      report("unexpected transfer", 1, 0);
      return;
    end
    v = vertex_q.pop_front();
    if (m_tdata[15:0] !== v.row) report("vertex_row", m_tdata[15:0], v.row);
    if (m_tdata[25:16] !== v.col) report("vertex_col", m_tdata[25:16], v.col);
    if (m_tdata[33:26] !== v.height) report("vertex_height", m_tdata[33:26], v.height);
    if (m_tdata[49:34] !== v.nx)
      report("normal_x", $signed(m_tdata[49:34]), v.nx);
    if (m_tdata[65:50] !== v.ny)
      report("normal_y", $signed(m_tdata[65:50]), v.ny);
    if (m_tdata[81:66] !== v.nz)
      report("normal_z", $signed(m_tdata[81:66]), v.nz);
    if (m_tlast !== v.run_end) report("run_end", m_tlast, v.run_end);
    if (m_tuser !== v.grid_done) report("grid_done", m_tuser, v.grid_done);
  endtask

  // Follow every transfer on the three channels
  always @(posedge clk) begin
    if (rst) begin
      errors = 0;
      width_reg = 11'd256;
      height_reg = 16'd256;
      for (int i = 0; i < SLOTS; i++) height_mem[i] = 8'd0;
      clear_grid();
      vertex_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_vertex();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_WIDTH) begin
          width_reg = cfg_data[10:0];
          clear_grid();
        end else if (cfg_index == REG_GRID_HEIGHT) begin
          height_reg = cfg_data;
          clear_grid();
        end
      end
      if (s_tvalid && s_tready) take_sample(s_tdata);
    end
    pending <= vertex_q.size();
  end

endmodule

/* tb/sv/heightmap_grid_vertex_normals_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heightmap_grid_vertex_normals_test
// Drives height samples over many small grids and a few extreme settings,
// with random idling on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module heightmap_grid_vertex_normals_test;
  import hgvn_pkg::*;

  localparam int SETTLE = 1500;
  localparam int LIMIT  = 20000;
  localparam int HOLD   = 3000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [87:0] m_tdata;   // row, col, height, normal x, y, z, zero fill
  logic        m_tlast;   // run_end
  logic        m_tuser;   // grid_done
  int          errors;
  int          pending;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          hold_left = 0;
  bit          hold_req = 0;
  bit          hold_taken = 0;
  int          quiet = 0;
  int          sent = 0;

  logic [7:0] w_list[9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd128,
                            8'd255};

  always #2 clk = ~clk;

  heightmap_grid_vertex_normals uut (.*);

  heightmap_grid_vertex_normals_checker vertex_check (.*);

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1;
      hold_left = HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_grid(input logic [15:0] w, input logic [15:0] h);
    s_tvalid <= 0;
    wait_idle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
  endtask

  // Offer one sample, leaving valid high for a possible back-to-back transfer
  task automatic send_sample(input logic [7:0] hs);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= hs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [7:0] pick_height();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(8));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int w, h, n;
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed: clamped small grid with extreme heights
    set_grid(16'd1, 16'd0);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd255);
    send_sample(8'd0);
    // 3x3 grid with extreme slopes; two unknown register indexes in between
    set_grid(16'd3, 16'd3);
    write_reg(2'd2, 16'hFFFF);
    write_reg(2'd3, 16'h5A5A);
    foreach (w_list[i]) send_sample(w_list[i]);
    // Widest grid (clamped) and tallest height: first row closes no cell
    set_grid(16'hFFFF, 16'hFFFF);
    repeat (6) send_sample(pick_height());
    // Narrow and very tall: after the first row, each second-column sample closes a cell
    set_grid(16'd2, 16'hFFFF);
    repeat (6) send_sample(pick_height());

    // Random grids in four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 60 : (ph == 3) ? 33 : 0;
      recv_stall = (ph == 2) ? 60 : (ph == 3) ? 33 : 0;
      while (sent < 20 + 68 * (ph + 1)) begin
        w = $urandom_range(2, 6);
        h = $urandom_range(2, 5);
        n = w * h;
        if ($urandom_range(7) == 0) begin
          h = 16'hFFFF;
          n = w * $urandom_range(2, 4);
        end
        set_grid(w[15:0], h[15:0]);
        if (ph == 0 && !hold_req) hold_req = 1;
        repeat (n) send_sample(pick_height());
      end
    end
    s_tvalid <= 0;

    wait_idle();
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* heightmap_grid_vertex_normals.f */
hw/rtl/hgvn_pkg.sv
hw/rtl/hgvn_unit_norm.sv
hw/rtl/hgvn_core.sv
hw/rtl/heightmap_grid_vertex_normals.sv
tb/sv/heightmap_grid_vertex_normals_checker.sv
tb/sv/heightmap_grid_vertex_normals_test.sv
